FILE: rtl/itpq_pkg.sv
`default_nettype none

package itpq_pkg;

  // table size and derived widths
  localparam int TASK_SLOTS = 64;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int USER_W = 16;
  localparam int TID_W  = 6;
  localparam int PRIO_W = 31;

  // item operations
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_EDIT   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_EXEC   = 2'd3
  } mode_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [USER_W-1:0] user_id;
    logic [TID_W-1:0]  task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [USER_W-1:0] user_id_out;
  } out_item_t;

  // running best candidate handed from cell to cell
  typedef struct packed {
    logic              have;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
    logic [USER_W-1:0] user;
  } cand_t;

  // slot update broadcast to the row
  typedef struct packed {
    logic              wr;
    logic              present_val;
    logic              set_user;
    logic              set_prio;
    logic [IDX_W-1:0]  idx;
    logic [USER_W-1:0] user;
    logic [PRIO_W-1:0] prio;
  } slot_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/itpq_cell.sv
`default_nettype none

module itpq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [itpq_pkg::IDX_W-1:0] slot_idx,
  input  wire itpq_pkg::slot_cmd_t       cmd,
  input  wire itpq_pkg::cand_t           cand_in,
  output itpq_pkg::cand_t                cand_out
);

  logic                        present;
  logic [itpq_pkg::USER_W-1:0] user;
  logic [itpq_pkg::PRIO_W-1:0] prio;
  logic                        hit;
  logic                        take;

  assign hit = cmd.wr && (cmd.idx == slot_idx);

  // slot contents
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      user    <= '0;
    end else if (hit) begin
      present <= cmd.present_val;
      if (cmd.set_user) begin
        user <= cmd.user;
      end
    end
  end

  // priority has no reset value
  always_ff @(posedge clk) begin
    if (hit && cmd.set_prio) begin
      prio <= cmd.prio;
    end
  end

  // later slot wins ties
  assign take = present && (!cand_in.have || (prio >= cand_in.prio));

  // hand the better candidate to the next cell
  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.have <= 1'b1;
      cand_out.prio <= prio;
      cand_out.idx  <= slot_idx;
      cand_out.user <= user;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itpq_ctrl.sv
`default_nettype none

module itpq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire itpq_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output itpq_pkg::out_item_t       out_item,
  input  wire itpq_pkg::cand_t      tail,
  output itpq_pkg::slot_cmd_t       cmd
);

  itpq_pkg::state_t state;
  itpq_pkg::state_t state_next;
  logic [itpq_pkg::CNT_W-1:0] cnt;
  logic [itpq_pkg::CNT_W-1:0] cnt_next;

  logic accept;
  logic is_exec;
  logic in_range;
  logic capture;
  logic out_free;
  logic [itpq_pkg::IDX_W+itpq_pkg::TID_W-1:0] task_wide;

  assign task_wide = {{itpq_pkg::IDX_W{1'b0}}, in_item.task_id};
  assign in_range  = task_wide < itpq_pkg::TASK_SLOTS;
  assign is_exec   = in_item.mode == itpq_pkg::MODE_EXEC;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      itpq_pkg::ST_IDLE: begin
        if (accept && is_exec) begin
          state_next = itpq_pkg::ST_SCAN;
          cnt_next   = '0;
        end
      end
      itpq_pkg::ST_SCAN: begin
        if (cnt != itpq_pkg::CNT_W'(itpq_pkg::TASK_SLOTS)) begin
          cnt_next = cnt + 1'b1;
        end else if (out_free) begin
          state_next = itpq_pkg::ST_IDLE;
        end
      end
      default: state_next = itpq_pkg::ST_IDLE;
    endcase
  end

  // outputs and slot commands
  always_comb begin
    in_stall = 1'b0;
    capture  = 1'b0;
    cmd      = '0;
    case (state)
      itpq_pkg::ST_IDLE: begin
        cmd.idx  = task_wide[itpq_pkg::IDX_W-1:0];
        cmd.user = in_item.user_id;
        cmd.prio = in_item.priority_req;
        cmd.wr   = accept && !is_exec && in_range;
        case (in_item.mode)
          itpq_pkg::MODE_ADD: begin
            cmd.present_val = 1'b1;
            cmd.set_user    = 1'b1;
            cmd.set_prio    = 1'b1;
          end
          itpq_pkg::MODE_EDIT: begin
            cmd.present_val = 1'b1;
            cmd.set_prio    = 1'b1;
          end
          default: begin
            cmd.present_val = 1'b0;
          end
        endcase
      end
      itpq_pkg::ST_SCAN: begin
        in_stall = 1'b1;
        capture  = (cnt == itpq_pkg::CNT_W'(itpq_pkg::TASK_SLOTS)) && out_free;
        // retire the winning slot
        cmd.wr  = capture && tail.have;
        cmd.idx = tail.idx;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itpq_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (capture) begin
      out_item.found       <= tail.have;
      out_item.user_id_out <= tail.have ? tail.user : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/indexed_task_priority_queue_top.sv
`default_nettype none

// Task table of TASK_SLOTS slots (64), one cell per slot in a row. Add, edit
// and remove items are taken while idle and produce no result.
// Execute-top offers its result once the scan of the row is done and takes
// the next item in the cycle after; the input is stalled meanwhile. The
// running best candidate moves one cell per cycle down the row, so the row
// length sets how long the scan lasts. The result sits in an output register,
// so add, edit and remove items are taken while it waits; a following execute
// holds its result and the input until the register is free. Ties in priority
// go to the larger task number.
module indexed_task_priority_queue_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire itpq_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output itpq_pkg::out_item_t      out_item
);

  itpq_pkg::cand_t     cand [itpq_pkg::TASK_SLOTS+1];
  itpq_pkg::slot_cmd_t cmd;

  // row starts with no candidate
  assign cand[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < itpq_pkg::TASK_SLOTS; i++) begin : g_cell
    itpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_idx (itpq_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .cand_in  (cand[i]),
      .cand_out (cand[i+1])
    );
  end

  // sequencer and result register
  itpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .tail      (cand[itpq_pkg::TASK_SLOTS]),
    .cmd       (cmd)
  );

endmodule

`default_nettype wire
